// ----- rtl/core/wft_pkg.sv -----
// shared constants and types of the word frequency table
package wft_pkg;

    localparam int ENTRIES     = 16;
    localparam int MAX_LEN     = 128;
    localparam int QUEUE_DEPTH = 4;

    localparam int OUTCOME_W = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 32;
    localparam int WLEN_W    = 8;
    localparam int BYTE_W    = 8;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CH_W  = $clog2(MAX_LEN);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int EA_W  = $clog2(ENTRIES * MAX_LEN);
    localparam int QP_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NEW  = 2'd0,
        OUT_HIT  = 2'd1,
        OUT_FULL = 2'd2
    } t_outcome;

    typedef struct packed {
        logic              is_letter;
        logic [BYTE_W-1:0] ch;
    } t_token;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_RD,
        ST_CMP,
        ST_CPRD,
        ST_CPWR,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/wft_channels_if.sv -----
// valid/ready channels for text bytes and word results
interface wft_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface wft_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [3:0]  entry_slot;
    logic [31:0] occurrences;
    logic [7:0]  word_length;

    modport source (output valid, output outcome, output entry_slot,
                    output occurrences, output word_length, input ready);
    modport sink   (input valid, input outcome, input entry_slot,
                    input occurrences, input word_length, output ready);
endinterface

// ----- rtl/core/wft_ram.sv -----
// generic single write port ram with registered read
module wft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/wft_front.sv -----
// front end: classifies text bytes and queues them as tokens
module wft_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wft_byte_if.sink        i_byte,
    output wft_pkg::t_token o_tok,
    output logic            o_tok_valid,
    input  logic            i_tok_ready
);
    import wft_pkg::*;

    t_token            r_q [QUEUE_DEPTH];
    logic [QP_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0]   r_count, n_count;
    logic              push, pop;
    t_token            tok_in;

    function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
        ptr_inc = (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // ascii letters only, case kept
    always_comb begin
        tok_in.ch        = i_byte.text_byte;
        tok_in.is_letter = ((i_byte.text_byte >= 8'd65) && (i_byte.text_byte <= 8'd90)) ||
                           ((i_byte.text_byte >= 8'd97) && (i_byte.text_byte <= 8'd122));
    end

    assign i_byte.ready = (r_count != QC_W'(QUEUE_DEPTH));
    assign push         = i_byte.valid && i_byte.ready;
    assign o_tok_valid  = (r_count != '0);
    assign pop          = o_tok_valid && i_tok_ready;
    assign o_tok        = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= tok_in;
        end
    end

endmodule

// ----- rtl/core/wft_back.sv -----
// back end: builds words, scans and updates the table, holds the result register
module wft_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wft_pkg::t_token i_tok,
    input  logic            i_tok_valid,
    output logic            o_tok_ready,
    wft_result_if.source    o_result
);
    import wft_pkg::*;

    t_state               r_state, n_state;
    logic [LEN_W-1:0]     r_word_len, n_word_len;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [CNT_W-1:0]     r_e, n_e;
    logic [CH_W-1:0]      r_i, n_i;
    logic [LEN_W-1:0]     r_len [ENTRIES];
    logic [COUNT_W-1:0]   r_cnt [ENTRIES];

    t_outcome             r_res_outcome, n_res_outcome;
    logic [SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic [COUNT_W-1:0]   r_res_count, n_res_count;

    logic                 r_out_valid, n_out_valid;
    t_outcome             r_out_outcome, n_out_outcome;
    logic [SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [COUNT_W-1:0]   r_out_count, n_out_count;
    logic [WLEN_W-1:0]    r_out_len, n_out_len;

    logic [IDX_W-1:0]     e_idx;
    logic [EA_W-1:0]      ent_addr;
    logic [BYTE_W-1:0]    word_q, entry_q;
    logic                 word_we, entry_we;
    logic                 len_we, cnt_we;
    logic [COUNT_W-1:0]   cnt_wdata;
    logic [COUNT_W-1:0]   cnt_cur, cnt_inc;
    logic                 e_in, len_match, char_eq, last_char, room, out_free;

    assign e_idx     = r_e[IDX_W-1:0];
    assign ent_addr  = EA_W'(e_idx) * EA_W'(MAX_LEN) + EA_W'(r_i);
    assign e_in      = (r_e < r_used);
    assign len_match = (r_len[e_idx] == r_word_len);
    assign char_eq   = (word_q == entry_q);
    assign last_char = (LEN_W'(r_i) == (r_word_len - 1'b1));
    assign room      = (r_used < CNT_W'(ENTRIES));
    assign out_free  = !r_out_valid || o_result.ready;
    assign cnt_cur   = r_cnt[e_idx];
    // count saturates at all ones
    assign cnt_inc   = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;

    wft_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (r_word_len[CH_W-1:0]),
        .i_wdata (i_tok.ch),
        .i_raddr (r_i),
        .o_rdata (word_q)
    );

    wft_ram #(.WIDTH(BYTE_W), .DEPTH(ENTRIES * MAX_LEN)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (entry_we),
        .i_waddr (ent_addr),
        .i_wdata (word_q),
        .i_raddr (ent_addr),
        .o_rdata (entry_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_tok_valid && !i_tok.is_letter && (r_word_len != '0)) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (e_in) begin
                    if (len_match) begin
                        n_state = ST_RD;
                    end
                end else if (room) begin
                    n_state = ST_CPRD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (!char_eq) begin
                    n_state = ST_LEN;
                end else if (last_char) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_CPRD: begin
                n_state = ST_CPWR;
            end
            ST_CPWR: begin
                if (last_char) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CPRD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_word_len    = r_word_len;
        n_used        = r_used;
        n_e           = r_e;
        n_i           = r_i;
        n_res_outcome = r_res_outcome;
        n_res_slot    = r_res_slot;
        n_res_count   = r_res_count;
        n_out_valid   = r_out_valid && !o_result.ready;
        n_out_outcome = r_out_outcome;
        n_out_slot    = r_out_slot;
        n_out_count   = r_out_count;
        n_out_len     = r_out_len;
        o_tok_ready   = 1'b0;
        word_we       = 1'b0;
        entry_we      = 1'b0;
        len_we        = 1'b0;
        cnt_we        = 1'b0;
        cnt_wdata     = cnt_inc;
        case (r_state)
            ST_IDLE: begin
                o_tok_ready = 1'b1;
                if (i_tok_valid) begin
                    if (i_tok.is_letter) begin
                        // letters past the buffer length are dropped
                        if (r_word_len < LEN_W'(MAX_LEN)) begin
                            word_we    = 1'b1;
                            n_word_len = r_word_len + 1'b1;
                        end
                    end else if (r_word_len != '0) begin
                        n_e = '0;
                    end
                end
            end
            ST_LEN: begin
                n_i = '0;
                if (e_in) begin
                    if (!len_match) begin
                        n_e = r_e + 1'b1;
                    end
                end else if (room) begin
                    n_e = r_used;
                end else begin
                    n_res_outcome = OUT_FULL;
                    n_res_slot    = '0;
                    n_res_count   = '0;
                end
            end
            ST_CMP: begin
                if (!char_eq) begin
                    n_e = r_e + 1'b1;
                end else if (last_char) begin
                    cnt_we        = 1'b1;
                    cnt_wdata     = cnt_inc;
                    n_res_outcome = OUT_HIT;
                    n_res_slot    = SLOT_W'(e_idx);
                    n_res_count   = cnt_inc;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_CPWR: begin
                entry_we = 1'b1;
                if (last_char) begin
                    len_we        = 1'b1;
                    cnt_we        = 1'b1;
                    cnt_wdata     = COUNT_W'(1);
                    n_used        = r_used + 1'b1;
                    n_res_outcome = OUT_NEW;
                    n_res_slot    = SLOT_W'(e_idx);
                    n_res_count   = COUNT_W'(1);
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_outcome = r_res_outcome;
                    n_out_slot    = r_res_slot;
                    n_out_count   = r_res_count;
                    n_out_len     = WLEN_W'(r_word_len);
                    n_word_len    = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_word_len  <= '0;
            r_used      <= '0;
            r_e         <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ENTRIES; k++) begin
                r_len[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_word_len  <= n_word_len;
            r_used      <= n_used;
            r_e         <= n_e;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
            if (len_we) begin
                r_len[e_idx] <= r_word_len;
            end
            if (cnt_we) begin
                r_cnt[e_idx] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_outcome <= n_res_outcome;
        r_res_slot    <= n_res_slot;
        r_res_count   <= n_res_count;
        r_out_outcome <= n_out_outcome;
        r_out_slot    <= n_out_slot;
        r_out_count   <= n_out_count;
        r_out_len     <= n_out_len;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.outcome     = r_out_outcome;
    assign o_result.entry_slot  = r_out_slot;
    assign o_result.occurrences = r_out_count;
    assign o_result.word_length = r_out_len;

endmodule

// ----- rtl/core/word_frequency_table_top.sv -----
// word frequency table: byte classifier and queue feeding the table sequencer
// a letter is stored when the sequencer takes it; a 4-entry queue takes bytes meanwhile
// at a word end used entries of equal length are compared letter by letter, and with
// no match and room the word is copied in; the scan shares one entry ram read port
// the result sits in an output register, so the next bytes are taken while it waits
// synchronous active-low reset empties the table and queue at once, no clearing pass
module word_frequency_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wft_byte_if.sink      i_byte,
    wft_result_if.source  o_result
);
    import wft_pkg::*;

    t_token tok;
    logic   tok_valid;
    logic   tok_ready;

    wft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_tok       (tok),
        .o_tok_valid (tok_valid),
        .i_tok_ready (tok_ready)
    );

    wft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok),
        .i_tok_valid (tok_valid),
        .o_tok_ready (tok_ready),
        .o_result    (o_result)
    );

endmodule
